[src/tccs_pkg.sv]
package tccs_pkg;

    localparam int NUM_UNITS       = 6;
    localparam int UNITS_PER_MOTOR = 3;
    localparam int COUNT_WIDTH     = 16;

    localparam int FIELD_W   = 6;
    localparam int MOTOR_W   = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 4;
    localparam int ALARM_W   = 16;

    localparam int IDX_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int SUB_W = (UNITS_PER_MOTOR > 1) ? $clog2(UNITS_PER_MOTOR) : 1;
    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_FWD   = 2'd1;
    localparam logic [1:0] PH_PAUSE = 2'd2;
    localparam logic [1:0] PH_REV   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DOWN       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_UP         = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_HALF = CFG_IDX_W'(3);

    localparam logic [CFG_W-1:0] RST_DOWN       = CFG_W'(5000);
    localparam logic [CFG_W-1:0] RST_PAUSE      = CFG_W'(900);
    localparam logic [CFG_W-1:0] RST_UP         = CFG_W'(5000);
    localparam logic [CFG_W-1:0] RST_ALARM_HALF = CFG_W'(200);

    typedef struct packed {
        logic [1:0]             phase;
        logic [COUNT_WIDTH-1:0] count;
    } t_unit;

    typedef struct packed {
        logic [CFG_W-1:0] down;
        logic [CFG_W-1:0] pause;
        logic [CFG_W-1:0] up;
        logic [CFG_W-1:0] alarm_half;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic fwd;
        logic rev;
    } t_unit_flags;

endpackage

[src/tccs_cfg.sv]
module tccs_cfg import tccs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.down       <= RST_DOWN;
            r_cfg.pause      <= RST_PAUSE;
            r_cfg.up         <= RST_UP;
            r_cfg.alarm_half <= RST_ALARM_HALF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DOWN:       r_cfg.down       <= i_cfg_data;
                REG_PAUSE:      r_cfg.pause      <= i_cfg_data;
                REG_UP:         r_cfg.up         <= i_cfg_data;
                REG_ALARM_HALF: r_cfg.alarm_half <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

[src/tccs_unit_mem.sv]
module tccs_unit_mem import tccs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_unit            o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_unit            i_wr_data
);

    t_unit                r_mem [NUM_UNITS];
    logic [NUM_UNITS-1:0] r_vld;
    t_unit                r_rd_data;
    logic                 r_rd_vld;

    // entries never written read as idle with zero count
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

endmodule

[src/tccs_unit_step.sv]
module tccs_unit_step import tccs_pkg::*; (
    input  t_unit       i_cur,
    input  logic        i_kill,
    input  logic        i_start,
    input  logic        i_inhibit,
    input  t_cfg        i_cfg,
    output t_unit       o_next,
    output t_unit_flags o_flags
);

    logic [CFG_W-1:0] w_len;
    logic             w_done;

    always_comb begin
        unique case (i_cur.phase)
            PH_FWD:   w_len = i_cfg.down;
            PH_PAUSE: w_len = i_cfg.pause;
            default:  w_len = i_cfg.up;
        endcase
    end

    // a zero length ends on the first check, same as a length of one
    assign w_done = (CMP_W'(i_cur.count) >= CMP_W'(w_len)) || (&i_cur.count);

    always_comb begin
        o_next = i_cur;
        priority if (i_kill) begin
            o_next = '0;
        end else if (i_cur.phase == PH_IDLE) begin
            if (i_start && !i_inhibit) begin
                o_next.phase = PH_FWD;
                o_next.count = COUNT_WIDTH'(1);
            end
        end else if (w_done) begin
            if (i_cur.phase == PH_REV) begin
                o_next = '0;
            end else begin
                o_next.phase = i_cur.phase + 2'd1;
                o_next.count = COUNT_WIDTH'(1);
            end
        end else begin
            o_next.count = i_cur.count + COUNT_WIDTH'(1);
        end
    end

    assign o_flags.busy = (o_next.phase != PH_IDLE);
    assign o_flags.fwd  = (o_next.phase == PH_FWD);
    assign o_flags.rev  = (o_next.phase == PH_REV);

endmodule

[src/timed_cylinder_cycle_sequencer.sv]
// six-unit timed press sequencer, one input beat per millisecond tick
// input channel: i_in_valid / o_in_stall with pedal, stop and estop samples;
// a beat is taken when i_in_valid is high and o_in_stall is low
// output channel: o_out_valid / i_out_stall, one result beat per input beat,
// showing valve, motor, busy and alarm state after that tick
// config channel: i_cfg_valid / o_cfg_ready, index 0 down, 1 pause, 2 up,
// 3 alarm half period; ready is always high, other indexes are dropped
// unit phase and count live in a single-port-read memory; each tick walks
// the units one per cycle, read then update and write back
// a result beat leaves once the last unit is written back, via the pending
// flag and the output register; no new tick is taken during the unit walk;
// the next tick is taken while the previous result waits in the output
// register; if the receiver stalls, the finished result is held internally
// and the input side stalls until the output register frees up
// reset: all units idle, counts zero, alarm off, registers to defaults,
// no result pending
module timed_cylinder_cycle_sequencer import tccs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [FIELD_W-1:0]   i_start_pedals,
    input  logic [FIELD_W-1:0]   i_inhibit_pedals,
    input  logic                 i_stop_request,
    input  logic                 i_estop_held,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [FIELD_W-1:0]   o_forward_drive,
    output logic [FIELD_W-1:0]   o_reverse_drive,
    output logic [MOTOR_W-1:0]   o_motor_drive,
    output logic [FIELD_W-1:0]   o_busy_units,
    output logic                 o_alarm_on,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_UNITS - 1);
    localparam logic [SUB_W-1:0] LAST_SUB = SUB_W'(UNITS_PER_MOTOR - 1);
    localparam int               UNIT_SPAN = 2 ** IDX_W;

    t_cfg        w_cfg;
    t_unit       w_rd_data;
    t_unit       w_next;
    t_unit_flags w_flags;

    logic r_act;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_grp;
    logic [SUB_W-1:0] r_sub;
    logic r_s2_valid;
    logic [IDX_W-1:0] r_s2_idx;
    logic [IDX_W-1:0] r_s2_grp;
    logic r_pend;

    logic [FIELD_W-1:0] r_start;
    logic [FIELD_W-1:0] r_inhibit;
    logic               r_kill;

    logic [ALARM_W-1:0] r_alarm_cnt;
    logic               r_alarm_lvl;
    logic [ALARM_W-1:0] n_alarm_cnt;
    logic               n_alarm_lvl;
    logic [ALARM_W:0]   w_alarm_inc;

    logic [NUM_UNITS-1:0] r_acc_fwd;
    logic [NUM_UNITS-1:0] r_acc_rev;
    logic [NUM_UNITS-1:0] r_acc_busy;
    logic [MOTOR_W-1:0]   r_acc_motor;
    logic                 r_acc_alarm;

    logic                 r_out_valid;
    logic [FIELD_W-1:0]   r_out_fwd;
    logic [FIELD_W-1:0]   r_out_rev;
    logic [FIELD_W-1:0]   r_out_busy;
    logic [MOTOR_W-1:0]   r_out_motor;
    logic                 r_out_alarm;

    logic w_accept;
    logic w_xfer;
    logic w_s2_start;
    logic w_s2_inhibit;

    logic [UNIT_SPAN-1:0]         w_start_ext;
    logic [UNIT_SPAN-1:0]         w_inhibit_ext;
    logic [NUM_UNITS+FIELD_W-1:0] w_fwd_ext;
    logic [NUM_UNITS+FIELD_W-1:0] w_rev_ext;
    logic [NUM_UNITS+FIELD_W-1:0] w_busy_ext;

    tccs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tccs_unit_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_act),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data),
        .i_wr_en   (r_s2_valid),
        .i_wr_addr (r_s2_idx),
        .i_wr_data (w_next)
    );

    // units beyond the pedal fields never start
    assign w_start_ext   = UNIT_SPAN'(r_start);
    assign w_inhibit_ext = UNIT_SPAN'(r_inhibit);
    assign w_s2_start    = w_start_ext[r_s2_idx];
    assign w_s2_inhibit  = w_inhibit_ext[r_s2_idx];

    tccs_unit_step u_step (
        .i_cur     (w_rd_data),
        .i_kill    (r_kill),
        .i_start   (w_s2_start),
        .i_inhibit (w_s2_inhibit),
        .i_cfg     (w_cfg),
        .o_next    (w_next),
        .o_flags   (w_flags)
    );

    assign w_xfer     = r_pend && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_act || r_s2_valid || (r_pend && !w_xfer);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_alarm_inc = {1'b0, r_alarm_cnt} + (ALARM_W + 1)'(1);

    always_comb begin
        if (i_estop_held) begin
            n_alarm_lvl = r_alarm_lvl ^ (r_alarm_cnt == '0);
            if (w_alarm_inc >= {1'b0, w_cfg.alarm_half}) begin
                n_alarm_cnt = '0;
            end else begin
                n_alarm_cnt = w_alarm_inc[ALARM_W-1:0];
            end
        end else begin
            n_alarm_lvl = 1'b0;
            n_alarm_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_start   <= i_start_pedals;
            r_inhibit <= i_inhibit_pedals;
            r_kill    <= i_stop_request || i_estop_held;
        end
        r_s2_idx <= r_idx;
        r_s2_grp <= r_grp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_idx       <= '0;
            r_grp       <= '0;
            r_sub       <= '0;
            r_s2_valid  <= 1'b0;
            r_pend      <= 1'b0;
            r_alarm_cnt <= '0;
            r_alarm_lvl <= 1'b0;
        end else begin
            r_s2_valid <= r_act;
            if (w_accept) begin
                r_act       <= 1'b1;
                r_idx       <= '0;
                r_grp       <= '0;
                r_sub       <= '0;
                r_alarm_cnt <= n_alarm_cnt;
                r_alarm_lvl <= n_alarm_lvl;
            end else if (r_act) begin
                if (r_idx == LAST_IDX) begin
                    r_act <= 1'b0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
                if (r_sub == LAST_SUB) begin
                    r_sub <= '0;
                    r_grp <= r_grp + IDX_W'(1);
                end else begin
                    r_sub <= r_sub + SUB_W'(1);
                end
            end
            if (r_s2_valid && r_s2_idx == LAST_IDX) begin
                r_pend <= 1'b1;
            end else if (w_xfer) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_acc_fwd   <= '0;
            r_acc_rev   <= '0;
            r_acc_busy  <= '0;
            r_acc_motor <= '0;
            r_acc_alarm <= n_alarm_lvl;
        end else if (r_s2_valid) begin
            r_acc_fwd[r_s2_idx]  <= w_flags.fwd;
            r_acc_rev[r_s2_idx]  <= w_flags.rev;
            r_acc_busy[r_s2_idx] <= w_flags.busy;
            // motor groups above the second are dropped
            if ((r_s2_grp >> 1) == '0 && (w_flags.fwd || w_flags.rev)) begin
                r_acc_motor[r_s2_grp[0]] <= 1'b1;
            end
        end
    end

    assign w_fwd_ext  = {{FIELD_W{1'b0}}, r_acc_fwd};
    assign w_rev_ext  = {{FIELD_W{1'b0}}, r_acc_rev};
    assign w_busy_ext = {{FIELD_W{1'b0}}, r_acc_busy};

    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_out_fwd   <= w_fwd_ext[FIELD_W-1:0];
            r_out_rev   <= w_rev_ext[FIELD_W-1:0];
            r_out_busy  <= w_busy_ext[FIELD_W-1:0];
            r_out_motor <= r_acc_motor;
            r_out_alarm <= r_acc_alarm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_xfer) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_forward_drive = r_out_fwd;
    assign o_reverse_drive = r_out_rev;
    assign o_busy_units    = r_out_busy;
    assign o_motor_drive   = r_out_motor;
    assign o_alarm_on      = r_out_alarm;

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (!r_act && !r_s2_valid))
        else $error("tick taken while unit walk in progress");

    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_act && r_idx == '0))
        else $error("unit walk did not start at unit zero");

    a_pend_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !r_act)
        else $error("result pending while units still being read");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_idx == LAST_IDX) |=> r_pend)
        else $error("last unit update did not mark result pending");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
    import tccs_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0] fwd;
        logic [FIELD_W-1:0] rev;
        logic [MOTOR_W-1:0] motor;
        logic [FIELD_W-1:0] busy;
        logic               alarm;
    } t_drive;

    class press_scoreboard;
        logic [CFG_W-1:0]       down_len;
        logic [CFG_W-1:0]       pause_len;
        logic [CFG_W-1:0]       up_len;
        logic [CFG_W-1:0]       alarm_half;
        logic [1:0]             unit_ph [NUM_UNITS];
        logic [COUNT_WIDTH-1:0] unit_cnt [NUM_UNITS];
        logic [ALARM_W-1:0]     alarm_cnt;
        logic                   alarm_lvl;
        t_drive                 expected_drives [$];
        int                     errors;

        function new();
            down_len   = RST_DOWN;
            pause_len  = RST_PAUSE;
            up_len     = RST_UP;
            alarm_half = RST_ALARM_HALF;
            for (int u = 0; u < NUM_UNITS; u++) begin
                unit_ph[u]  = PH_IDLE;
                unit_cnt[u] = '0;
            end
            alarm_cnt = '0;
            alarm_lvl = 1'b0;
            errors    = 0;
        endfunction

        function void report(string msg);
            $display("%0t ns mismatch: %s", $realtime, msg);
            errors++;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_DOWN:       down_len   = val;
                REG_PAUSE:      pause_len  = val;
                REG_UP:         up_len     = val;
                REG_ALARM_HALF: alarm_half = val;
                default: ;
            endcase
        endfunction

        function logic [CFG_W-1:0] stroke_len(logic [1:0] ph);
            if (ph == PH_FWD) return down_len;
            if (ph == PH_PAUSE) return pause_len;
            return up_len;
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction

        function void note_tick(logic [FIELD_W-1:0] start, logic [FIELD_W-1:0] inhibit,
                                logic stop, logic estop);
            t_drive             exp;
            logic [ALARM_W:0]   next_alarm;
            logic [1:0]         ph;
            logic [COUNT_WIDTH-1:0] c;
            exp = '0;
            if (estop) begin
                if (alarm_cnt == '0) alarm_lvl = ~alarm_lvl;
                next_alarm = {1'b0, alarm_cnt} + 1'b1;
                if (next_alarm >= {1'b0, alarm_half} || next_alarm[ALARM_W])
                    alarm_cnt = '0;
                else
                    alarm_cnt = next_alarm[ALARM_W-1:0];
            end else begin
                alarm_cnt = '0;
                alarm_lvl = 1'b0;
            end
            for (int u = 0; u < NUM_UNITS; u++) begin
                ph = unit_ph[u];
                if (estop || stop) begin
                    ph          = PH_IDLE;
                    unit_cnt[u] = '0;
                end else if (ph == PH_IDLE) begin
                    if (u < FIELD_W && start[u] && !inhibit[u]) begin
                        ph          = PH_FWD;
                        unit_cnt[u] = COUNT_WIDTH'(1);
                    end
                end else begin
                    c = unit_cnt[u];
                    if (c >= stroke_len(ph) || c == '1) begin
                        ph          = (ph == PH_REV) ? PH_IDLE : ph + 2'd1;
                        unit_cnt[u] = (ph == PH_IDLE) ? '0 : COUNT_WIDTH'(1);
                    end else begin
                        unit_cnt[u] = c + 1'b1;
                    end
                end
                unit_ph[u] = ph;
                if (u < FIELD_W) begin
                    exp.busy[u] = (ph != PH_IDLE);
                    exp.fwd[u]  = (ph == PH_FWD);
                    exp.rev[u]  = (ph == PH_REV);
                end
                if ((ph == PH_FWD || ph == PH_REV) && u / UNITS_PER_MOTOR < MOTOR_W)
                    exp.motor[u / UNITS_PER_MOTOR] = 1'b1;
            end
            exp.alarm = alarm_lvl;
            expected_drives.push_back(exp);
        endfunction

        function void check_outputs(t_drive got);
            t_drive exp;
            if (expected_drives.size() == 0) begin
                report($sformatf("result beat with nothing expected: %h", got));
                return;
            end
            exp = expected_drives.pop_front();
            if (got.fwd !== exp.fwd)
                report($sformatf("forward_drive exp %h got %h", exp.fwd, got.fwd));
            if (got.rev !== exp.rev)
                report($sformatf("reverse_drive exp %h got %h", exp.rev, got.rev));
            if (got.motor !== exp.motor)
                report($sformatf("motor_drive exp %h got %h", exp.motor, got.motor));
            if (got.busy !== exp.busy)
                report($sformatf("busy_units exp %h got %h", exp.busy, got.busy));
            if (got.alarm !== exp.alarm)
                report($sformatf("alarm_on exp %b got %b", exp.alarm, got.alarm));
        endfunction

        function int finish();
            if (expected_drives.size() != 0)
                report($sformatf("%0d result beats never arrived", expected_drives.size()));
            return errors;
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [FIELD_W-1:0]   i_start_pedals;
    logic [FIELD_W-1:0]   i_inhibit_pedals;
    logic                 i_stop_request;
    logic                 i_estop_held;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [FIELD_W-1:0]   o_forward_drive;
    logic [FIELD_W-1:0]   o_reverse_drive;
    logic [MOTOR_W-1:0]   o_motor_drive;
    logic [FIELD_W-1:0]   o_busy_units;
    logic                 o_alarm_on;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    press_scoreboard sb = new();
    logic            quiet;
    int              estop_run;

    timed_cylinder_cycle_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_start_pedals  (i_start_pedals),
        .i_inhibit_pedals(i_inhibit_pedals),
        .i_stop_request  (i_stop_request),
        .i_estop_held    (i_estop_held),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_forward_drive (o_forward_drive),
        .o_reverse_drive (o_reverse_drive),
        .o_motor_drive   (o_motor_drive),
        .o_busy_units    (o_busy_units),
        .o_alarm_on      (o_alarm_on),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= (!i_rst_n || quiet) ? 1'b0 : ($urandom_range(99) < 23);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_outputs({o_forward_drive, o_reverse_drive, o_motor_drive,
                              o_busy_units, o_alarm_on});
    end

    task automatic send_tick(input logic [FIELD_W-1:0] start, input logic [FIELD_W-1:0] inhibit,
                             input logic stop, input logic estop);
        while (!quiet && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_start_pedals   <= start;
        i_inhibit_pedals <= inhibit;
        i_stop_request   <= stop;
        i_estop_held     <= estop;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_tick(start, inhibit, stop, estop);
    endtask

    // hold off until every result beat is back, then let the unit walk settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (NUM_UNITS + 6) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, CFG_W'(val));
    endtask

    task automatic apply_timing(input int unsigned down, input int unsigned pause,
                                input int unsigned up, input int unsigned half);
        cfg_write(REG_DOWN, down);
        cfg_write(REG_PAUSE, pause);
        cfg_write(REG_UP, up);
        cfg_write(REG_ALARM_HALF, half);
        cfg_write(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_ALARM_HALF + 1)),
                  $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_tick();
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] inhibit;
        logic               stop;
        start   = FIELD_W'($urandom) & ($urandom_range(1) ? '1 : FIELD_W'($urandom));
        inhibit = ($urandom_range(2) == 0) ? FIELD_W'($urandom & $urandom) : '0;
        stop    = ($urandom_range(99) < 3);
        if (estop_run == 0 && $urandom_range(99) < 2)
            estop_run = $urandom_range(40, 1);
        send_tick(start, inhibit, stop, estop_run != 0);
        if (estop_run != 0) estop_run--;
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_start_pedals   <= '0;
        i_inhibit_pedals <= '0;
        i_stop_request   <= 1'b0;
        i_estop_held     <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= '0;
        i_cfg_data       <= '0;
        quiet            = 1'b0;
        estop_run        = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset timing
        send_tick('1, '0, 1'b0, 1'b0);
        send_tick('0, '0, 1'b0, 1'b0);
        send_tick('0, '0, 1'b1, 1'b0);
        drain();

        apply_timing(2, 1, 3, 3);
        send_tick('0, '0, 1'b0, 1'b0);
        send_tick('1, '0, 1'b0, 1'b0);
        send_tick('1, '1, 1'b0, 1'b0);
        repeat (7) send_tick('1, '0, 1'b0, 1'b0);
        send_tick('1, 6'h2A, 1'b0, 1'b0);
        send_tick(6'h15, '0, 1'b0, 1'b0);
        send_tick('1, '0, 1'b1, 1'b0);
        repeat (7) send_tick('1, '0, 1'b0, 1'b1);
        send_tick('1, '0, 1'b1, 1'b1);
        send_tick('0, '0, 1'b0, 1'b0);
        drain();

        // alarm half period lowered mid-half
        apply_timing(2, 1, 3, 40);
        repeat (10) send_tick('1, '0, 1'b0, 1'b1);
        drain();
        cfg_write(REG_ALARM_HALF, 2);
        i_cfg_valid <= 1'b0;
        repeat (4) send_tick('0, '0, 1'b0, 1'b1);
        send_tick('1, '0, 1'b0, 1'b0);
        drain();

        // zero lengths
        apply_timing(0, 0, 0, 0);
        repeat (4) send_tick('1, '0, 1'b0, 1'b0);
        repeat (3) send_tick('0, '0, 1'b0, 1'b1);
        send_tick('1, '0, 1'b0, 1'b0);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                1: apply_timing(1, 1, 1, 1);
                2: apply_timing($urandom_range(30, 1), $urandom_range(30, 1),
                                $urandom_range(30, 1), $urandom_range(20, 1));
                3: apply_timing($urandom_range(6, 1), $urandom_range(6, 1),
                                $urandom_range(6, 1), $urandom_range(6, 1));
                4: apply_timing('1, '1, '1, '1);
                5: apply_timing($urandom, $urandom, $urandom, $urandom);
                6: apply_timing($urandom_range(4, 1), $urandom_range(4, 1),
                                $urandom_range(4, 1), $urandom_range(4, 1));
                default: apply_timing($urandom_range(12, 1), $urandom_range(12, 1),
                                      $urandom_range(12, 1), $urandom_range(8, 1));
            endcase
            quiet     = (p == 3);
            estop_run = 0;
            repeat (205) random_tick();
            drain();
        end
        quiet = 1'b0;

        if (sb.finish() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
